@@ design/ttce_pkg.sv @@
// Package for the text terminal character engine.
// Holds screen geometry, character codes and shared types; depends on nothing.
package ttce_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W = 11;
    localparam int ROW_W = 5;
    localparam int COL_W = 7;
    localparam int CELL_W = 16;

    // Saturation value of the command number.
    localparam int NUM_SAT = 65535;
    // Scaled reciprocals used to reduce the running remainders of the command
    // number by ROWS and COLUMNS after each digit.
    localparam int ROW_RECIP = (1 << 10) / ROWS + 1;
    localparam int COL_RECIP = (1 << 14) / COLUMNS + 1;

    localparam logic [7:0] RESET_COLOR = 8'h0F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;
    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_RBR = 8'h5D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_Y = 8'h79;
    localparam logic [7:0] CH_X = 8'h78;
    localparam logic [7:0] CH_U = 8'h75;
    localparam logic [7:0] CH_D = 8'h64;
    localparam logic [7:0] CH_L = 8'h6C;
    localparam logic [7:0] CH_R = 8'h72;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic            operation;
        logic [7:0]      char_code;
        logic [ADDR_W-1:0] cell_address;
    } in_beat_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
    } out_beat_t;

endpackage

@@ design/ttce_if.sv @@
// Valid/ready channel interface carrying one beat of payload.
// Depends on ttce_pkg for the payload types.
interface ttce_in_if import ttce_pkg::*; ();
    logic     valid;
    logic     ready;
    in_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ttce_out_if import ttce_pkg::*; ();
    logic      valid;
    logic      ready;
    out_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/ttce_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module ttce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ design/text_terminal_character_engine_core.sv @@
// Top level of the text terminal character engine: sequencer and cursor state.
// Depends on ttce_pkg, ttce_if and ttce_ram.
//
//  channel | direction | fields
//  in_ch   | sink      | operation, char_code, cell_address
//  out_ch  | source    | cell_value, cursor_row, cursor_column
//
// Each beat is handled one at a time. A read passes through S_DECODE and
// S_RDWAIT, a printed character or a cursor command through S_DECODE and S_OUT,
// before its result is registered; a tab writes one blank per cycle, up to 4.
// A row blank writes COLUMNS cells, a clear CELL_COUNT, and a scroll moves the
// CELL_COUNT - COLUMNS cells below the top row up one row through the single
// read port of the screen RAM, then blanks the last row of COLUMNS cells.
// The next beat can be taken in the cycle after the result beat leaves.
// After reset a clearing pass writes all CELL_COUNT cells with no beat
// accepted. The result sits in an output register; a stalled sink holds it
// while the block waits to take the next beat.
module text_terminal_character_engine_core
    import ttce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ttce_in_if.sink    in_ch,
    ttce_out_if.source out_ch
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_DECODE = 8'b0000_0100,
        S_RDWAIT = 8'b0000_1000,
        S_FILL   = 8'b0001_0000,
        S_SCRRD  = 8'b0010_0000,
        S_SCRWR  = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [7:0]        color_reg, color_next;
    logic              esc_reg, esc_next;
    logic [15:0]       num_reg, num_next;
    logic [ROW_W-1:0]  ymod_reg, ymod_next;   // command number mod ROWS
    logic [COL_W-1:0]  xmod_reg, xmod_next;   // command number mod COLUMNS
    logic [ADDR_W-1:0] ptr_reg, ptr_next;     // sweep pointer
    logic [ADDR_W-1:0] end_reg, end_next;     // sweep end (exclusive)
    logic              tab_reg, tab_next;     // fill is a tab run
    logic              sc_reg, sc_next;       // fill follows a scroll
    in_beat_t          beat_reg, beat_next;
    out_beat_t         res_reg, res_next;
    logic              ovalid_reg, ovalid_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [CELL_W-1:0] wr_data, rd_data;

    ttce_ram #(.WIDTH(CELL_W), .DEPTH(1 << ADDR_W)) u_screen (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    logic [CELL_W-1:0] blank;
    logic [ADDR_W-1:0] cur_addr, row_base;
    logic [19:0]       num_x10;
    logic [3:0]        digit;
    logic [16:0]       dsum, rsum;
    logic [7:0]        ysum;
    logic [9:0]        xsum;
    logic [3:0]        yq, xq;
    logic [ROW_W-1:0]  ywrap;
    logic [COL_W-1:0]  xwrap;

    assign blank = {color_reg, CH_SPACE};
    assign row_base = ADDR_W'(row_reg * COL_W'(COLUMNS));
    assign cur_addr = row_base + ADDR_W'(col_reg);
    assign digit = 4'(beat_reg.char_code - CH_0);
    assign num_x10 = 20'(num_reg) * 20'd10 + 20'(digit);
    assign dsum = 17'(row_reg) + 17'(num_reg);
    assign rsum = 17'(col_reg) + 17'(num_reg);

    // The remainders follow the number digit by digit: the previous remainder
    // times ten plus the digit stays small, and a scaled reciprocal gives its
    // quotient exactly, so one multiply and subtract reduce it again.
    assign ysum = 8'(ymod_reg) * 8'd10 + 8'(digit);
    assign yq = 4'((16'(ysum) * 16'(ROW_RECIP)) >> 10);
    assign ywrap = ROW_W'(ysum - 8'(yq) * 8'(ROWS));
    assign xsum = 10'(xmod_reg) * 10'd10 + 10'(digit);
    assign xq = 4'((18'(xsum) * 18'(COL_RECIP)) >> 14);
    assign xwrap = COL_W'(xsum - 10'(xq) * 10'(COLUMNS));

    assign in_ch.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data = res_reg;

    always_comb
    begin
        logic [COL_W:0] col_inc;
        state_next = state_reg;
        row_next = row_reg;
        col_next = col_reg;
        color_next = color_reg;
        esc_next = esc_reg;
        num_next = num_reg;
        ymod_next = ymod_reg;
        xmod_next = xmod_reg;
        ptr_next = ptr_reg;
        end_next = end_reg;
        tab_next = tab_reg;
        sc_next = sc_reg;
        beat_next = beat_reg;
        res_next = res_reg;
        ovalid_next = ovalid_reg;
        wr_en = 1'b0;
        wr_addr = ptr_reg;
        wr_data = blank;
        rd_addr = beat_reg.cell_address;
        col_inc = {1'b0, col_reg} + 1'b1;

        if (ovalid_reg && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
                wr_data = {RESET_COLOR, CH_SPACE};
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    beat_next = in_ch.data;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_OUT;
                if (beat_reg.operation == OP_READ)
                begin
                    state_next = S_RDWAIT;
                end
                else if (esc_reg && beat_reg.char_code >= CH_0
                         && beat_reg.char_code <= CH_9)
                begin
                    if (num_x10 > 20'(NUM_SAT))
                    begin
                        num_next = 16'(NUM_SAT);
                        ymod_next = ROW_W'(NUM_SAT % ROWS);
                        xmod_next = COL_W'(NUM_SAT % COLUMNS);
                    end
                    else
                    begin
                        num_next = num_x10[15:0];
                        ymod_next = ywrap;
                        xmod_next = xwrap;
                    end
                end
                else if (esc_reg && (beat_reg.char_code == CH_LBR))
                begin
                end
                else if (esc_reg && (beat_reg.char_code == CH_RBR))
                begin
                    esc_next = 1'b0;
                end
                else if (esc_reg && (beat_reg.char_code == CH_COLON))
                begin
                    row_next = '0;
                    col_next = '0;
                    ptr_next = '0;
                    end_next = ADDR_W'(CELL_COUNT);
                    tab_next = 1'b0;
                    sc_next = 1'b0;
                    state_next = S_FILL;
                end
                else if (esc_reg && (beat_reg.char_code == CH_DOT))
                begin
                    col_next = '0;
                    ptr_next = row_base;
                    end_next = row_base + ADDR_W'(COLUMNS);
                    tab_next = 1'b0;
                    sc_next = 1'b0;
                    state_next = S_FILL;
                end
                else if (esc_reg && (beat_reg.char_code == CH_UNDER))
                begin
                    color_next = RESET_COLOR;
                end
                else if (esc_reg && (beat_reg.char_code == CH_F
                         || beat_reg.char_code == CH_B || beat_reg.char_code == CH_Y
                         || beat_reg.char_code == CH_X || beat_reg.char_code == CH_U
                         || beat_reg.char_code == CH_D || beat_reg.char_code == CH_L
                         || beat_reg.char_code == CH_R))
                begin
                    num_next = '0;
                    ymod_next = '0;
                    xmod_next = '0;
                    case (beat_reg.char_code)
                        CH_F: color_next = {color_reg[7:4], num_reg[3:0]};
                        CH_B: color_next = {num_reg[3:0], color_reg[3:0]};
                        CH_Y: row_next = ymod_reg;
                        CH_X: col_next = xmod_reg;
                        CH_U: row_next = (num_reg >= 16'(row_reg)) ? '0
                                         : ROW_W'(16'(row_reg) - num_reg);
                        CH_D: row_next = (dsum >= 17'(ROWS - 1)) ? ROW_W'(ROWS - 1)
                                         : ROW_W'(dsum);
                        CH_L: col_next = (num_reg >= 16'(col_reg)) ? '0
                                         : COL_W'(16'(col_reg) - num_reg);
                        default: col_next = (rsum >= 17'(COLUMNS - 1))
                                         ? COL_W'(COLUMNS - 1) : COL_W'(rsum);
                    endcase
                end
                else
                begin
                    // Plain byte (also leaves command mode).
                    esc_next = 1'b0;
                    if (beat_reg.char_code == CH_LF || beat_reg.char_code == CH_CR)
                    begin
                        col_next = '0;
                        if (row_reg == ROW_W'(ROWS - 1))
                        begin
                            ptr_next = '0;
                            state_next = S_SCRRD;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else if (beat_reg.char_code == CH_ESC)
                    begin
                        esc_next = 1'b1;
                        num_next = '0;
                        ymod_next = '0;
                        xmod_next = '0;
                    end
                    else
                    begin
                        // Tab or printable: write one cell and advance.
                        wr_en = 1'b1;
                        wr_addr = cur_addr;
                        wr_data = (beat_reg.char_code == CH_TAB) ? blank
                                  : {color_reg, beat_reg.char_code};
                        tab_next = (beat_reg.char_code == CH_TAB);
                        if (col_inc == (COL_W+1)'(COLUMNS))
                        begin
                            col_next = '0;
                            if (row_reg == ROW_W'(ROWS - 1))
                            begin
                                ptr_next = '0;
                                state_next = S_SCRRD;
                            end
                            else
                            begin
                                row_next = row_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            col_next = col_inc[COL_W-1:0];
                            if (beat_reg.char_code == CH_TAB && col_inc[1:0] != 2'b00)
                            begin
                                state_next = S_DECODE;
                            end
                        end
                    end
                end
            end
            S_RDWAIT:
            begin
                res_next.cell_value = (beat_reg.cell_address < ADDR_W'(CELL_COUNT))
                                      ? rd_data : '0;
                res_next.cursor_row = row_reg;
                res_next.cursor_column = col_reg;
                ovalid_next = 1'b1;
                state_next = S_IDLE;
            end
            S_FILL:
            begin
                wr_en = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg + 1'b1 == end_reg)
                begin
                    // After a scroll blank, a tab may still need more cells.
                    state_next = (sc_reg && tab_reg && col_reg[1:0] != 2'b00)
                                 ? S_DECODE : S_OUT;
                end
            end
            S_SCRRD:
            begin
                // Read the cell one row below the pointer.
                rd_addr = ptr_reg + ADDR_W'(COLUMNS);
                state_next = S_SCRWR;
            end
            S_SCRWR:
            begin
                wr_en = 1'b1;
                wr_data = rd_data;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == ADDR_W'(CELL_COUNT - COLUMNS - 1))
                begin
                    end_next = ADDR_W'(CELL_COUNT);
                    sc_next = 1'b1;
                    state_next = S_FILL;
                end
                else
                begin
                    state_next = S_SCRRD;
                end
            end
            S_OUT:
            begin
                res_next.cell_value = '0;
                res_next.cursor_row = row_reg;
                res_next.cursor_column = col_reg;
                ovalid_next = 1'b1;
                sc_next = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            row_reg <= '0;
            col_reg <= '0;
            color_reg <= RESET_COLOR;
            esc_reg <= 1'b0;
            num_reg <= '0;
            ymod_reg <= '0;
            xmod_reg <= '0;
            ptr_reg <= '0;
            end_reg <= '0;
            tab_reg <= 1'b0;
            sc_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg <= row_next;
            col_reg <= col_next;
            color_reg <= color_next;
            esc_reg <= esc_next;
            num_reg <= num_next;
            ymod_reg <= ymod_next;
            xmod_reg <= xmod_next;
            ptr_reg <= ptr_next;
            end_reg <= end_next;
            tab_reg <= tab_next;
            sc_reg <= sc_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
        res_reg <= res_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        row_reg < ROW_W'(ROWS)) else $error("cursor row out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < COL_W'(COLUMNS)) else $error("cursor column out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !ovalid_reg) else $error("accept while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !out_ch.ready) |=> ovalid_reg) else $error("result lost");

endmodule
